FILE: rtl/sfdx_pkg.sv
package sfdx_pkg;

    // Largest number of bytes taken in from the length byte through the checksum
    localparam int unsigned MAX_BUFFER_BYTES = 64;

    // Payload store geometry
    localparam int unsigned BUF_DEPTH  = 64;
    localparam int unsigned BUF_AW     = $clog2(BUF_DEPTH);
    localparam int unsigned CNT_W      = 7;

    localparam logic [7:0] SYNC_A   = 8'h55;
    localparam logic [7:0] SYNC_B   = 8'hAA;
    localparam logic [7:0] SYNC_C   = 8'hDC;
    localparam logic [7:0] LEN_MASK = 8'h3F;

    typedef enum logic [2:0] {
        ST_H1   = 3'd0,
        ST_H2   = 3'd1,
        ST_H3   = 3'd2,
        ST_LEN  = 3'd3,
        ST_ID   = 3'd4,
        ST_DATA = 3'd5,
        ST_CRC  = 3'd6
    } t_parse_state;

endpackage

FILE: rtl/serial_frame_deframer_xor_core.sv
// Channel | direction | handshake          | payload
// --------+-----------+--------------------+------------------------------------------
// rx      | in        | i_valid / o_stall  | i_rx_byte
// frame   | out       | o_valid / i_stall  | o_frame_tag, o_byte_index, o_data_byte, o_last
//
// A received byte is taken in while i_valid is high and o_stall is low; bytes may arrive in every cycle while no frame
// is being emitted. A good checksum starts an emission run of N results (N data bytes),
// one result per cycle when the output side does not stall; the single-port payload RAM sets
// this: one read a cycle. The checksum transfer sets r_busy, which starts the reads into the output register.
// o_stall stays high until the last byte has been read, so no byte is written while the
// RAM is being read. Reset is synchronous and active low; the RAM contents are not cleared.
module serial_frame_deframer_xor_core
    import sfdx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // receive channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    // frame channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_tag,
    output logic [5:0] o_byte_index,
    output logic [7:0] o_data_byte,
    output logic       o_last
);

    // Payload RAM: written while parsing, read during emission
    logic [7:0] r_mem [BUF_DEPTH];

    // Parser state
    t_parse_state      r_state,        n_state;
    logic [5:0]        r_frame_len,    n_frame_len;
    logic [7:0]        r_frame_ident,  n_frame_ident;
    logic [BUF_AW-1:0] r_pcount,       n_pcount;
    logic [7:0]        r_xor,          n_xor;
    logic [CNT_W-1:0]  r_stored,       n_stored;

    // Emission state
    logic              r_busy,         n_busy;
    logic [BUF_AW-1:0] r_rd_idx,       n_rd_idx;
    logic [BUF_AW-1:0] r_emit_cnt,     n_emit_cnt;

    // Output register (data byte comes straight from the RAM read register)
    logic              r_out_valid,    n_out_valid;
    logic [7:0]        r_out_id;
    logic [5:0]        r_out_index;
    logic              r_out_last;
    logic [7:0]        r_rd_data;

    logic              in_xfer;
    logic              out_xfer;
    logic              rd_en;
    logic              wr_en;
    logic [CNT_W-1:0]  stored_inc;
    logic              overflow;
    logic [BUF_AW-1:0] pcount_inc;
    logic              rd_last;

    assign o_stall  = r_busy;
    assign in_xfer  = i_valid && !r_busy;
    assign out_xfer = r_out_valid && !i_stall;

    // Issue a read whenever the output slot is empty or is being emptied this cycle
    assign rd_en   = r_busy && (!r_out_valid || out_xfer);
    assign rd_last = (r_rd_idx == r_emit_cnt - BUF_AW'(1));

    assign stored_inc = r_stored + CNT_W'(1);
    assign overflow   = stored_inc > CNT_W'(MAX_BUFFER_BYTES);
    assign pcount_inc = r_pcount + BUF_AW'(1);
    assign wr_en      = in_xfer && (r_state == ST_DATA);

    // Parser next state and emission control
    always_comb begin
        n_state       = r_state;
        n_frame_len   = r_frame_len;
        n_frame_ident = r_frame_ident;
        n_pcount      = r_pcount;
        n_xor         = r_xor;
        n_stored      = r_stored;
        n_busy        = r_busy;
        n_rd_idx      = r_rd_idx;
        n_emit_cnt    = r_emit_cnt;
        n_out_valid   = r_out_valid;

        // Output side: advance the read pointer, drop the run flag after the last read
        if (rd_en) begin
            n_out_valid = 1'b1;
            n_rd_idx    = r_rd_idx + BUF_AW'(1);
            if (rd_last) begin
                n_busy = 1'b0;
            end
        end else if (out_xfer) begin
            n_out_valid = 1'b0;
        end

        if (in_xfer) begin
            n_stored = stored_inc;
            unique case (r_state)
                ST_H2: begin
                    n_state  = (i_rx_byte == SYNC_B) ? ST_H3 : ST_H1;
                    n_stored = '0;
                end
                ST_H3: begin
                    n_state  = (i_rx_byte == SYNC_C) ? ST_LEN : ST_H1;
                    n_stored = '0;
                end
                ST_LEN: begin
                    n_frame_len = 6'(i_rx_byte & LEN_MASK);
                    n_xor       = i_rx_byte;
                    n_state     = ST_ID;
                end
                ST_ID: begin
                    n_frame_ident = i_rx_byte;
                    n_xor         = r_xor ^ i_rx_byte;
                    n_pcount      = '0;
                    n_state       = ST_DATA;
                end
                ST_DATA: begin
                    n_xor    = r_xor ^ i_rx_byte;
                    n_pcount = pcount_inc;
                    if (r_frame_len <= 6'd3 ||
                        6'(pcount_inc) >= r_frame_len - 6'd3) begin
                        n_state = ST_CRC;
                    end
                end
                ST_CRC: begin
                    // Good checksum: start the emission run
                    if (!overflow && i_rx_byte == r_xor) begin
                        n_busy     = 1'b1;
                        n_rd_idx   = '0;
                        n_emit_cnt = r_pcount;
                    end
                    n_state  = ST_H1;
                    n_stored = '0;
                end
                default: begin
                    n_state  = (i_rx_byte == SYNC_A) ? ST_H2 : ST_H1;
                    n_stored = '0;
                end
            endcase

            // Too many bytes for the buffer: drop the frame
            if (overflow && (r_state == ST_LEN || r_state == ST_ID ||
                             r_state == ST_DATA)) begin
                n_state  = ST_H1;
                n_stored = '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_H1;
            r_frame_len   <= '0;
            r_frame_ident <= '0;
            r_pcount      <= '0;
            r_xor         <= '0;
            r_stored      <= '0;
            r_busy        <= 1'b0;
            r_rd_idx      <= '0;
            r_emit_cnt    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_frame_len   <= n_frame_len;
            r_frame_ident <= n_frame_ident;
            r_pcount      <= n_pcount;
            r_xor         <= n_xor;
            r_stored      <= n_stored;
            r_busy        <= n_busy;
            r_rd_idx      <= n_rd_idx;
            r_emit_cnt    <= n_emit_cnt;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload RAM write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pcount] <= i_rx_byte;
        end
    end

    // Payload RAM read port; the read register doubles as the output data register
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data   <= r_mem[r_rd_idx];
            r_out_id    <= r_frame_ident;
            r_out_index <= 6'(r_rd_idx);
            r_out_last  <= rd_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame_tag  = r_out_id;
    assign o_byte_index = r_out_index;
    assign o_data_byte  = r_rd_data;
    assign o_last       = r_out_last;

endmodule

FILE: rtl/sfdx_checker.sv
module sfdx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_frame_tag,
    input logic [5:0] o_byte_index,
    input logic [7:0] o_data_byte,
    input logic       o_last
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data_byte) && $stable(o_byte_index)
                               && $stable(o_frame_tag) && $stable(o_last))
        else $error("stalled result changed");

    // Mid-frame the receive side stays stalled
    a_rx_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("receive side open during a frame");

    // The next result of a frame follows at once, with the next index and the same id
    a_run_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=>
            o_valid && o_byte_index == 6'($past(o_byte_index) + 6'd1)
            && o_frame_tag == $past(o_frame_tag))
        else $error("frame run broken");

    // Reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not empty after reset");

endmodule

bind serial_frame_deframer_xor_core sfdx_checker u_sfdx_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_frame_tag  (o_frame_tag),
    .o_byte_index (o_byte_index),
    .o_data_byte  (o_data_byte),
    .o_last       (o_last)
);
